### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk_sig, rst_n_sig, prop) \
	label: assert property (@(posedge clk_sig) disable iff (!(rst_n_sig)) (prop)) \
		else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk_sig, rst_n_sig, cond) \
	label: assert property (@(posedge clk_sig) disable iff (!(rst_n_sig)) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk_sig, rst_n_sig, prop)
`define ASSERT_NEVER(label, clk_sig, rst_n_sig, cond)

`endif

`endif

### hw/rtl/iirl_pkg.sv
`timescale 1ns / 1ps

package iirl_pkg;

	localparam int MODE_W   = 4;
	localparam int POS_W    = 5;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;
	// broadcast index width, covers every DEPTH up to 256
	localparam int IDX_W    = 8;

	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 4'd0;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 4'd1;
	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 4'd2;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 4'd3;
	localparam logic [MODE_W-1:0] MODE_INSERT     = 4'd4;
	localparam logic [MODE_W-1:0] MODE_REMOVE     = 4'd5;
	localparam logic [MODE_W-1:0] MODE_SET        = 4'd6;
	localparam logic [MODE_W-1:0] MODE_GET        = 4'd7;
	localparam logic [MODE_W-1:0] MODE_CLEAR      = 4'd8;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	// command kind, broadcast to every cell
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_INS  = 2'd1;
	localparam logic [1:0] KIND_DEL  = 2'd2;
	localparam logic [1:0] KIND_SET  = 2'd3;

	typedef struct packed {
		logic [1:0]       kind;
		logic [IDX_W-1:0] idx;
	} cell_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [POS_W-1:0]  position;
		logic [WORD_W-1:0] data_in;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   read_value;
		logic [COUNT_W-1:0]  count;
		logic                is_empty;
		logic [WORD_W-1:0]   first_value;
		logic [WORD_W-1:0]   last_value;
	} out_item_t;

endpackage

### hw/rtl/indexed_insert_remove_list.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_ready   | iirl_pkg::in_item_t  (mode, position, data_in)
// out     | output    | out_valid / out_ready | iirl_pkg::out_item_t (status .. last_value)
//
// Every transaction is applied to the cell row in the cycle it is accepted; all cells
// shift, load or hold together. The output register later forms the result from the row.
// A transaction can be accepted every cycle while the output drains.
// A full output register with out_ready low stalls the input after one more transaction.
// Reset clears the entry count and all valid flags; cell contents need no reset.

`include "assert_macros.svh"

module indexed_insert_remove_list #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  iirl_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output iirl_pkg::out_item_t out_data
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]                 count_q;
	logic                          accept;
	logic                          s1_go;
	logic                          s1_v_q;
	logic [iirl_pkg::STATUS_W-1:0] status_s1;
	logic [iirl_pkg::WORD_W-1:0]   rd_s1;
	logic                          out_valid_q;
	iirl_pkg::out_item_t           out_q;

	iirl_pkg::cell_cmd_t           dec_cmd;
	iirl_pkg::cell_cmd_t           cell_cmd;
	logic [iirl_pkg::STATUS_W-1:0] dec_status;
	logic                          dec_rd_en;
	logic [CW-1:0]                 dec_count_next;

	logic [DATA_WIDTH-1:0]         new_data;
	logic [iirl_pkg::IDX_W-1:0]    last_idx;
	logic [DATA_WIDTH-1:0]         cell_val  [DEPTH];
	logic [DATA_WIDTH-1:0]         rd_part   [DEPTH];
	logic [DATA_WIDTH-1:0]         last_part [DEPTH];
	logic [DATA_WIDTH-1:0]         rd_or;
	logic [DATA_WIDTH-1:0]         last_or;
	logic                          list_empty;

	assign s1_go    = s1_v_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_v_q || s1_go;
	assign accept   = in_valid && in_ready;

	iirl_ctrl #(
		.DEPTH(DEPTH),
		.CW   (CW)
	) u_ctrl (
		.mode      (in_data.mode),
		.position  (in_data.position),
		.count     (count_q),
		.cmd       (dec_cmd),
		.status    (dec_status),
		.rd_en     (dec_rd_en),
		.count_next(dec_count_next)
	);

	always_comb begin
		cell_cmd = dec_cmd;
		if (!accept) begin
			cell_cmd.kind = iirl_pkg::KIND_NONE;
		end
	end

	assign new_data = DATA_WIDTH'(in_data.data_in);
	assign last_idx = iirl_pkg::IDX_W'(count_q - CW'(1));

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_val;
		logic [DATA_WIDTH-1:0] right_val;

		if (i == 0) begin : g_first
			assign left_val = '0;
		end else begin : g_mid_l
			assign left_val = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_mid_r
			assign right_val = cell_val[i+1];
		end

		iirl_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.INDEX     (i)
		) u_cell (
			.clk      (clk),
			.cmd      (cell_cmd),
			.new_data (new_data),
			.left_val (left_val),
			.right_val(right_val),
			.last_idx (last_idx),
			.value    (cell_val[i]),
			.rd_part  (rd_part[i]),
			.last_part(last_part[i])
		);
	end

	always_comb begin
		rd_or   = '0;
		last_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or   = rd_or | rd_part[i];
			last_or = last_or | last_part[i];
		end
	end

	assign list_empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			s1_v_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= dec_count_next;
			end
			if (accept) begin
				s1_v_q <= 1'b1;
			end else if (s1_go) begin
				s1_v_q <= 1'b0;
			end
			if (s1_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// get reads the row before this transaction touches it
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= dec_status;
			rd_s1     <= dec_rd_en ? iirl_pkg::WORD_W'(rd_or) : '0;
		end
	end

	// row and count here already reflect the transaction held in stage one
	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_q.status      <= status_s1;
			out_q.read_value  <= rd_s1;
			out_q.count       <= iirl_pkg::COUNT_W'(count_q);
			out_q.is_empty    <= list_empty;
			out_q.first_value <= list_empty ? '0 : iirl_pkg::WORD_W'(cell_val[0]);
			out_q.last_value  <= list_empty ? '0 : iirl_pkg::WORD_W'(last_or);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CW'(DEPTH))
	`ASSERT_PROP(a_count_hold, clk, arst_n, !accept |=> $stable(count_q))
	`ASSERT_PROP(a_fail_no_change, clk, arst_n, accept && dec_status != iirl_pkg::ST_OK |=> $stable(count_q))
	`ASSERT_PROP(a_accept_to_s1, clk, arst_n, accept |=> s1_v_q)
	`ASSERT_PROP(a_out_from_s1, clk, arst_n, $rose(out_valid_q) |-> $past(s1_v_q))

endmodule

### hw/rtl/iirl_cell.sv
`timescale 1ns / 1ps

module iirl_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int INDEX      = 0
) (
	input  logic                            clk,
	input  iirl_pkg::cell_cmd_t             cmd,
	input  logic [DATA_WIDTH-1:0]           new_data,
	input  logic [DATA_WIDTH-1:0]           left_val,
	input  logic [DATA_WIDTH-1:0]           right_val,
	input  logic [iirl_pkg::IDX_W-1:0]      last_idx,
	output logic [DATA_WIDTH-1:0]           value,
	output logic [DATA_WIDTH-1:0]           rd_part,
	output logic [DATA_WIDTH-1:0]           last_part
);

	localparam logic [iirl_pkg::IDX_W-1:0] MY_IDX = iirl_pkg::IDX_W'(INDEX);

	logic [DATA_WIDTH-1:0] value_q;
	logic                  at_idx;
	logic                  above_idx;

	assign at_idx    = (cmd.idx == MY_IDX);
	assign above_idx = (MY_IDX > cmd.idx);

	always_ff @(posedge clk) begin
		case (cmd.kind)
			iirl_pkg::KIND_INS: begin
				// shift up from the insertion point
				if (at_idx) begin
					value_q <= new_data;
				end else if (above_idx) begin
					value_q <= left_val;
				end
			end
			iirl_pkg::KIND_DEL: begin
				// close the gap, last cell takes zero
				if (at_idx || above_idx) begin
					value_q <= right_val;
				end
			end
			iirl_pkg::KIND_SET: begin
				if (at_idx) begin
					value_q <= new_data;
				end
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

	assign value     = value_q;
	assign rd_part   = at_idx ? value_q : '0;
	assign last_part = (last_idx == MY_IDX) ? value_q : '0;

endmodule

### hw/rtl/iirl_ctrl.sv
`timescale 1ns / 1ps

module iirl_ctrl #(
	parameter int DEPTH = 16,
	parameter int CW    = 5
) (
	input  logic [iirl_pkg::MODE_W-1:0]   mode,
	input  logic [iirl_pkg::POS_W-1:0]    position,
	input  logic [CW-1:0]                 count,
	output iirl_pkg::cell_cmd_t           cmd,
	output logic [iirl_pkg::STATUS_W-1:0] status,
	output logic                          rd_en,
	output logic [CW-1:0]                 count_next
);

	localparam int XW = (CW > iirl_pkg::POS_W) ? CW : iirl_pkg::POS_W;

	logic [XW-1:0] cnt_x;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] p;
	logic          do_ins;
	logic          do_del;
	logic          do_set;
	logic          do_get;
	logic          do_clr;

	assign cnt_x = XW'(count);
	assign pos_x = XW'(position);

	always_comb begin
		do_ins = 1'b0;
		do_del = 1'b0;
		do_set = 1'b0;
		do_get = 1'b0;
		do_clr = 1'b0;
		p      = pos_x;
		case (mode)
			iirl_pkg::MODE_PUSH_BACK: begin
				do_ins = 1'b1;
				p      = cnt_x;
			end
			iirl_pkg::MODE_POP_BACK: begin
				// wraps on an empty list, caught by the empty check
				do_del = 1'b1;
				p      = cnt_x - XW'(1);
			end
			iirl_pkg::MODE_PUSH_FRONT: begin
				do_ins = 1'b1;
				p      = '0;
			end
			iirl_pkg::MODE_POP_FRONT: begin
				do_del = 1'b1;
				p      = '0;
			end
			iirl_pkg::MODE_INSERT: do_ins = 1'b1;
			iirl_pkg::MODE_REMOVE: do_del = 1'b1;
			iirl_pkg::MODE_SET: begin
				// set one past the end appends
				if (pos_x == cnt_x) begin
					do_ins = 1'b1;
				end else begin
					do_set = 1'b1;
				end
			end
			iirl_pkg::MODE_GET:   do_get = 1'b1;
			iirl_pkg::MODE_CLEAR: do_clr = 1'b1;
			default: begin
				do_ins = 1'b0;
			end
		endcase
	end

	always_comb begin
		status     = iirl_pkg::ST_OK;
		cmd.kind   = iirl_pkg::KIND_NONE;
		cmd.idx    = iirl_pkg::IDX_W'(p);
		rd_en      = 1'b0;
		count_next = count;
		if (do_ins) begin
			if (p > cnt_x) begin
				status = iirl_pkg::ST_RANGE;
			end else if (cnt_x >= XW'(DEPTH)) begin
				status = iirl_pkg::ST_FULL;
			end else begin
				cmd.kind   = iirl_pkg::KIND_INS;
				count_next = count + CW'(1);
			end
		end else if (do_del || do_get) begin
			if (cnt_x == '0) begin
				status = iirl_pkg::ST_EMPTY;
			end else if (p >= cnt_x) begin
				status = iirl_pkg::ST_RANGE;
			end else if (do_del) begin
				cmd.kind   = iirl_pkg::KIND_DEL;
				count_next = count - CW'(1);
			end else begin
				rd_en = 1'b1;
			end
		end else if (do_set) begin
			if (p > cnt_x) begin
				status = iirl_pkg::ST_RANGE;
			end else begin
				cmd.kind = iirl_pkg::KIND_SET;
			end
		end else if (do_clr) begin
			count_next = '0;
		end
	end

endmodule
